### rtl/sfm_pkg.sv
// shared types, field widths and codes for the sparse fixed-fanout matvec unit
// no dependencies; used by the channel interfaces and the top level
package sfm_pkg;

   // payload field widths
   localparam int FUNC_W     = 3;
   localparam int SLOT_W     = 12;
   localparam int TGT_W      = 12;
   localparam int WGT_W      = 17;
   localparam int VAL_W      = 32;
   localparam int MODE_W     = 2;
   localparam int ROW_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // configuration register widths
   localparam int NS_CFG_W = 11;
   localparam int AS_CFG_W = 3;
   localparam int NC_CFG_W = 9;

   // fraction bits of the Q16.16 result
   localparam int FRAC_W = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_ENTRY   = 3'd0,
      FUNC_WR_COUNTED = 3'd1,
      FUNC_WR_VECTORS = 3'd2,
      FUNC_COMPUTE    = 3'd3,
      FUNC_RD_RESULT  = 3'd4
   } func_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_FULL      = 2'd0,
      MODE_P_ONLY    = 2'd1,
      MODE_P_PLUS_QV = 2'd2,
      MODE_Q_ROWSUM  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_STATES  = 2'd0,
      CSR_ALPHABET    = 2'd1,
      CSR_NUM_COUNTED = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_TAB,
      ST_A_VEC,
      ST_A_MUL,
      ST_A_ACC,
      ST_A_ZERO,
      ST_B_LIST,
      ST_B_CHK,
      ST_B_TAB,
      ST_B_VEC,
      ST_B_MULV,
      ST_B_WAIT,
      ST_B_SUB,
      ST_B_ADD,
      ST_C_RD,
      ST_C_WR
   } state_type;

endpackage

### rtl/sfm_req_if.sv
// request channel: load, compute and read-back items
// depends on sfm_pkg for field widths
interface sfm_req_if;
   import sfm_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   slot_index;
   logic [TGT_W-1:0]    target_state;
   logic [WGT_W-1:0]    weight;
   logic signed [VAL_W-1:0] u_value;
   logic signed [VAL_W-1:0] v_value;
   logic [MODE_W-1:0]   mode;

   modport source (output valid, func, slot_index, target_state, weight, u_value, v_value,
                   mode, input ready);
   modport sink   (input valid, func, slot_index, target_state, weight, u_value, v_value,
                   mode, output ready);
endinterface

### rtl/sfm_rsp_if.sv
// response channel: one result element per transfer
// depends on sfm_pkg for field widths
interface sfm_rsp_if;
   import sfm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row_index;
   logic signed [VAL_W-1:0] result_value;
   logic                    saturated;

   modport source (output valid, row_index, result_value, saturated, input ready);
   modport sink   (input valid, row_index, result_value, saturated, output ready);
endinterface

### rtl/sfm_csr_if.sv
// configuration write channel: register index and write data
// depends on sfm_pkg for field widths
interface sfm_csr_if;
   import sfm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sfm_ram.sv
// generic single-port synchronous ram, read-first, registered read data
// no dependencies
module sfm_ram #(
   parameter int W     = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic [AW-1:0] addr,
   input  logic          we,
   input  logic [W-1:0]  wdata,
   output logic [W-1:0]  rdata
);

   logic [W-1:0] mem [DEPTH];

   // one access per cycle, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### rtl/sfm_div.sv
// restoring divider, one quotient bit per cycle, maps an entry position to its row
// no dependencies
module sfm_div #(
   parameter int N_W = 12,
   parameter int D_W = 3
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   div_ff, div_in;
   logic [D_W:0]     trial;

   // shift one dividend bit into the remainder and try to subtract
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[N_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(N_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = D_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = D_W'(trial);
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### rtl/sparse_fixed_fanout_matvec_unit.sv
// top level: sequencer over the entry, counted, vector, accumulator and result rams
// depends on sfm_pkg, sfm_req_if, sfm_rsp_if, sfm_csr_if, sfm_ram, sfm_div
//
// channel  | dir | transfer carries
// ---------+-----+----------------------------------------------------------------
// req_ch   | in  | func, slot_index, target_state, weight, u_value, v_value, mode
// rsp_ch   | out | row_index, result_value, saturated (one per in-range read item)
// csr_ch   | in  | index, data (num_states, alphabet_size, num_counted)
//
// load and read items are taken in the idle state; a read result goes through the
// result ram read register and then the response register; compute time is set by the
// single ram ports and the shared multiplier (mode 3 only zeroes the row accumulators)
// after reset a clearing pass zeroes all MAX_STATES result ram entries, req idle
// a waiting result does not stop loads; a second read waits in a one-entry skid stage
module sparse_fixed_fanout_matvec_unit #(
   parameter int MAX_STATES  = 1024,
   parameter int MAX_SYMBOLS = 4,
   parameter int MAX_COUNTED = 256
) (
   input  logic      clock,
   input  logic      reset,
   sfm_req_if.sink   req_ch,
   sfm_rsp_if.source rsp_ch,
   sfm_csr_if.sink   csr_ch
);
   import sfm_pkg::*;

   localparam int ST_W  = $clog2(MAX_STATES);
   localparam int NS_W  = $clog2(MAX_STATES + 1);
   localparam int K_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int TD    = MAX_STATES * MAX_SYMBOLS;
   localparam int TA_W  = $clog2(TD);
   localparam int CA_W  = (MAX_COUNTED > 1) ? $clog2(MAX_COUNTED) : 1;
   localparam int CN_W  = $clog2(MAX_COUNTED + 1);
   localparam int PR_W  = WGT_W + VAL_W + 1;
   localparam int ACC_W = PR_W + $clog2(MAX_SYMBOLS + 2 * MAX_COUNTED + 1);
   localparam int Q_W   = ACC_W - FRAC_W;
   localparam int TAB_W = TGT_W + WGT_W;
   localparam int RES_W = VAL_W + 1;

   // configuration registers
   logic [NS_CFG_W-1:0] num_states_ff;
   logic [AS_CFG_W-1:0] alphabet_ff;
   logic [NC_CFG_W-1:0] num_counted_ff;

   // sequencer state
   state_type  state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [NS_W-1:0]   n_ff, n_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [CN_W-1:0]   c_ff, c_in;
   logic [TA_W:0]     nk_ff, nk_in;
   logic [NS_W-1:0]   r_ff, r_in;
   logic [K_W-1:0]    j_ff, j_in;
   logic [TA_W-1:0]   e_ff, e_in;
   logic [CN_W-1:0]   i_ff, i_in;
   logic [ST_W-1:0]   row_ff, row_in;
   logic [WGT_W-1:0]  w_ff, w_in;
   logic              tin_ff, tin_in;
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, pu_ff, pu_in, pv_ff, pv_in;

   // read-back path
   logic             rd_pend_ff, rd_pend_in;
   logic [ROW_W-1:0] rd_row_ff, rd_row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [RES_W-1:0] rsp_res_ff, rsp_res_in;
   logic             skid_ff, skid_in;
   logic [ROW_W-1:0] skid_row_ff, skid_row_in;
   logic [RES_W-1:0] skid_res_ff, skid_res_in;

   // ram ports
   logic [TA_W-1:0]  tab_addr;
   logic             tab_we;
   logic [TAB_W-1:0] tab_wdata, tab_rdata;
   logic [CA_W-1:0]  cnt_addr;
   logic             cnt_we;
   logic [TGT_W-1:0] cnt_wdata, cnt_rdata;
   logic [ST_W-1:0]  vec_addr;
   logic             vec_we;
   logic [2*VAL_W-1:0] vec_wdata, vec_rdata;
   logic [ST_W-1:0]  acc_addr;
   logic             acc_we;
   logic [ACC_W-1:0] acc_wdata, acc_rdata;
   logic [ST_W-1:0]  res_addr;
   logic             res_we;
   logic [RES_W-1:0] res_wdata, res_rdata;

   // divider
   logic             div_start, div_busy;
   logic [TGT_W-1:0] div_quot;

   // misc combinational
   logic                    req_rdy, req_acc, rsp_free;
   logic [NS_W-1:0]         n_eff;
   logic [K_W-1:0]          k_eff;
   logic [CN_W-1:0]         c_eff;
   logic signed [WGT_W:0]   mul_a;
   logic signed [VAL_W-1:0] mul_b;
   logic signed [PR_W-1:0]  mul_p;
   logic signed [ACC_W-1:0] acc_sum, acc_src;
   logic signed [Q_W-1:0]   q_val;
   logic                    q_sat;
   logic [VAL_W-1:0]        q_out;
   logic [TGT_W-1:0]        tab_tgt;
   logic                    row_last, sym_last, cnt_last, res_last;

   // effective register values, clamped to the hardware limits (alphabet size at least 2)
   always_comb begin
      n_eff = (32'(num_states_ff) > 32'(MAX_STATES)) ? NS_W'(MAX_STATES)
                                                      : NS_W'(num_states_ff);
      if (32'(alphabet_ff) < 32'd2) begin
         k_eff = K_W'(2);
      end else if (32'(alphabet_ff) > 32'(MAX_SYMBOLS)) begin
         k_eff = K_W'(MAX_SYMBOLS);
      end else begin
         k_eff = K_W'(alphabet_ff);
      end
      c_eff = (32'(num_counted_ff) > 32'(MAX_COUNTED)) ? CN_W'(MAX_COUNTED)
                                                        : CN_W'(num_counted_ff);
   end

   // shared multiplier, unsigned weight by signed vector element
   assign mul_a = $signed({1'b0, w_ff});
   always_comb begin
      priority if (state_ff == ST_B_MULV) begin
         mul_b = v_ff;
      end else begin
         mul_b = tin_ff ? $signed(vec_rdata[VAL_W-1:0]) : '0;
      end
   end
   assign mul_p = mul_a * mul_b;

   // row finish: floor shift to Q16.16, then saturate
   assign acc_src = $signed(acc_rdata);
   assign q_val   = acc_src[ACC_W-1:FRAC_W];
   assign q_sat   = !((&q_val[Q_W-1:VAL_W-1]) || !(|q_val[Q_W-1:VAL_W-1]));
   assign q_out   = q_sat ? (q_val[Q_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                          : {1'b0, {(VAL_W-1){1'b1}}})
                          : q_val[VAL_W-1:0];

   assign acc_sum  = acc_ff + pu_ff;
   assign tab_tgt  = tab_rdata[TAB_W-1:WGT_W];
   assign row_last = (NS_W'(r_ff + 1'b1) == n_ff);
   assign sym_last = (K_W'(j_ff + 1'b1) == k_ff);
   assign cnt_last = (CN_W'(i_ff + 1'b1) == c_ff);
   assign res_last = (r_ff == NS_W'(MAX_STATES - 1));

   assign req_rdy  = (state_ff == ST_IDLE) && !skid_ff && !(rd_pend_ff && rsp_valid_ff);
   assign req_acc  = req_ch.valid && req_rdy;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer: next state, ram ports and datapath updates
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      c_in      = c_ff;
      nk_in     = nk_ff;
      r_in      = r_ff;
      j_in      = j_ff;
      e_in      = e_ff;
      i_in      = i_ff;
      row_in    = row_ff;
      w_in      = w_ff;
      tin_in    = tin_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      pu_in     = pu_ff;
      pv_in     = pv_ff;
      rd_pend_in = 1'b0;
      rd_row_in  = rd_row_ff;
      tab_addr  = e_ff;
      tab_we    = 1'b0;
      tab_wdata = {req_ch.target_state, req_ch.weight};
      cnt_addr  = i_ff[CA_W-1:0];
      cnt_we    = 1'b0;
      cnt_wdata = req_ch.target_state;
      vec_addr  = ST_W'(tab_tgt);
      vec_we    = 1'b0;
      vec_wdata = {req_ch.v_value, req_ch.u_value};
      acc_addr  = r_ff[ST_W-1:0];
      acc_we    = 1'b0;
      acc_wdata = acc_sum;
      res_addr  = r_ff[ST_W-1:0];
      res_we    = 1'b0;
      res_wdata = '0;
      div_start = 1'b0;

      unique case (state_ff)
         // zero the result ram after reset
         ST_CLEAR: begin
            res_we = 1'b1;
            r_in   = NS_W'(r_ff + 1'b1);
            if (res_last) begin
               r_in     = '0;
               state_in = ST_IDLE;
            end
         end

         // loads, reads and compute start
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_ch.func)
                  FUNC_WR_ENTRY: begin
                     tab_addr = TA_W'(req_ch.slot_index);
                     tab_we   = (32'(req_ch.slot_index) < 32'(TD));
                  end
                  FUNC_WR_COUNTED: begin
                     cnt_addr = CA_W'(req_ch.slot_index);
                     cnt_we   = (32'(req_ch.slot_index) < 32'(MAX_COUNTED));
                  end
                  FUNC_WR_VECTORS: begin
                     vec_addr = ST_W'(req_ch.slot_index);
                     vec_we   = (32'(req_ch.slot_index) < 32'(MAX_STATES));
                  end
                  FUNC_COMPUTE: begin
                     mode_in = req_ch.mode;
                     n_in    = n_eff;
                     k_in    = k_eff;
                     c_in    = c_eff;
                     nk_in   = (TA_W + 1)'(32'(n_eff) * 32'(k_eff));
                     r_in    = '0;
                     j_in    = '0;
                     e_in    = '0;
                     i_in    = '0;
                     acc_in  = '0;
                     priority if (n_eff == '0) begin
                        state_in = ST_C_RD;
                     end else if (req_ch.mode == MODE_Q_ROWSUM) begin
                        state_in = ST_A_ZERO;
                     end else begin
                        state_in = ST_A_TAB;
                     end
                  end
                  FUNC_RD_RESULT: begin
                     res_addr = ST_W'(req_ch.slot_index);
                     if (32'(req_ch.slot_index) < 32'(MAX_STATES)) begin
                        rd_pend_in = 1'b1;
                        rd_row_in  = req_ch.slot_index[ROW_W-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end

         // row pass: read entry, read vector element, multiply, accumulate
         ST_A_TAB: begin
            state_in = ST_A_VEC;
         end
         ST_A_VEC: begin
            w_in     = tab_rdata[WGT_W-1:0];
            tin_in   = (32'(tab_tgt) < 32'(n_ff));
            state_in = ST_A_MUL;
         end
         ST_A_MUL: begin
            pu_in    = ACC_W'(mul_p);
            state_in = ST_A_ACC;
         end
         ST_A_ACC: begin
            e_in = TA_W'(e_ff + 1'b1);
            if (sym_last) begin
               acc_we = 1'b1;
               acc_in = '0;
               j_in   = '0;
               r_in   = NS_W'(r_ff + 1'b1);
               if (row_last) begin
                  r_in = '0;
                  priority if (mode_ff == MODE_FULL || c_ff == '0) begin
                     state_in = ST_C_RD;
                  end else begin
                     state_in = ST_B_LIST;
                  end
               end else begin
                  state_in = ST_A_TAB;
               end
            end else begin
               acc_in   = acc_sum;
               j_in     = K_W'(j_ff + 1'b1);
               state_in = ST_A_TAB;
            end
         end
         ST_A_ZERO: begin
            acc_we    = 1'b1;
            acc_wdata = '0;
            r_in      = NS_W'(r_ff + 1'b1);
            if (row_last) begin
               r_in     = '0;
               state_in = (c_ff == '0) ? ST_C_RD : ST_B_LIST;
            end
         end

         // counted pass: one listed position at a time, read-modify-write of its row
         ST_B_LIST: begin
            state_in = ST_B_CHK;
         end
         ST_B_CHK: begin
            tab_addr = TA_W'(cnt_rdata);
            if (32'(cnt_rdata) >= 32'(nk_ff)) begin
               i_in = CN_W'(i_ff + 1'b1);
               state_in = cnt_last ? ST_C_RD : ST_B_LIST;
            end else begin
               div_start = 1'b1;
               state_in  = ST_B_TAB;
            end
         end
         ST_B_TAB: begin
            w_in     = tab_rdata[WGT_W-1:0];
            tin_in   = (32'(tab_tgt) < 32'(n_ff));
            state_in = ST_B_VEC;
         end
         ST_B_VEC: begin
            v_in     = tin_ff ? $signed(vec_rdata[2*VAL_W-1:VAL_W]) : '0;
            pu_in    = (mode_ff == MODE_Q_ROWSUM) ? '0 : ACC_W'(mul_p);
            state_in = ST_B_MULV;
         end
         ST_B_MULV: begin
            unique case (mode_ff)
               MODE_P_PLUS_QV: pv_in = ACC_W'(mul_p);
               MODE_Q_ROWSUM:  pv_in = $signed(ACC_W'({w_ff, {FRAC_W{1'b0}}}));
               default:        pv_in = '0;
            endcase
            state_in = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            acc_addr = ST_W'(div_quot);
            if (!div_busy) begin
               row_in   = ST_W'(div_quot);
               state_in = ST_B_SUB;
            end
         end
         ST_B_SUB: begin
            acc_in   = acc_src - pu_ff;
            state_in = ST_B_ADD;
         end
         ST_B_ADD: begin
            acc_addr  = row_ff;
            acc_we    = 1'b1;
            acc_wdata = acc_ff + pv_ff;
            i_in      = CN_W'(i_ff + 1'b1);
            state_in  = cnt_last ? ST_C_RD : ST_B_LIST;
         end

         // finish pass over every result element
         ST_C_RD: begin
            if (32'(r_ff) < 32'(n_ff)) begin
               state_in = ST_C_WR;
            end else begin
               res_we = 1'b1;
               r_in   = NS_W'(r_ff + 1'b1);
               if (res_last) begin
                  r_in     = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_C_WR: begin
            res_we    = 1'b1;
            res_wdata = {q_sat, q_out};
            r_in      = NS_W'(r_ff + 1'b1);
            if (res_last) begin
               r_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_C_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register and skid stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_res_in   = rsp_res_ff;
      skid_in      = skid_ff;
      skid_row_in  = skid_row_ff;
      skid_res_in  = skid_res_ff;
      if (rsp_free) begin
         priority if (skid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = skid_row_ff;
            rsp_res_in   = skid_res_ff;
            skid_in      = 1'b0;
         end else if (rd_pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = rd_row_ff;
            rsp_res_in   = res_rdata;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (rd_pend_ff) begin
         skid_in     = 1'b1;
         skid_row_in = rd_row_ff;
         skid_res_in = res_rdata;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         r_ff           <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         skid_ff        <= 1'b0;
         num_states_ff  <= NS_CFG_W'(1024);
         alphabet_ff    <= AS_CFG_W'(4);
         num_counted_ff <= '0;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_ff      <= skid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_NUM_STATES:  num_states_ff  <= csr_ch.data[NS_CFG_W-1:0];
               CSR_ALPHABET:    alphabet_ff    <= csr_ch.data[AS_CFG_W-1:0];
               CSR_NUM_COUNTED: num_counted_ff <= csr_ch.data[NC_CFG_W-1:0];
               default: ;
            endcase
         end
      end
      mode_ff     <= mode_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      c_ff        <= c_in;
      nk_ff       <= nk_in;
      j_ff        <= j_in;
      e_ff        <= e_in;
      i_ff        <= i_in;
      row_ff      <= row_in;
      w_ff        <= w_in;
      tin_ff      <= tin_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      pu_ff       <= pu_in;
      pv_ff       <= pv_in;
      rd_row_ff   <= rd_row_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_res_ff  <= rsp_res_in;
      skid_row_ff <= skid_row_in;
      skid_res_ff <= skid_res_in;
   end

   // channel outputs
   assign req_ch.ready        = req_rdy;
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.row_index    = rsp_row_ff;
   assign rsp_ch.result_value = $signed(rsp_res_ff[VAL_W-1:0]);
   assign rsp_ch.saturated    = rsp_res_ff[VAL_W];

   // entry table: target column and weight
   sfm_ram #(.W(TAB_W), .DEPTH(TD), .AW(TA_W)) u_tab_ram (
      .clock (clock), .addr (tab_addr), .we (tab_we), .wdata (tab_wdata), .rdata (tab_rdata)
   );

   // counted position list
   sfm_ram #(.W(TGT_W), .DEPTH(MAX_COUNTED), .AW(CA_W)) u_cnt_ram (
      .clock (clock), .addr (cnt_addr), .we (cnt_we), .wdata (cnt_wdata), .rdata (cnt_rdata)
   );

   // u and v side by side
   sfm_ram #(.W(2 * VAL_W), .DEPTH(MAX_STATES), .AW(ST_W)) u_vec_ram (
      .clock (clock), .addr (vec_addr), .we (vec_we), .wdata (vec_wdata), .rdata (vec_rdata)
   );

   // wide row accumulators
   sfm_ram #(.W(ACC_W), .DEPTH(MAX_STATES), .AW(ST_W)) u_acc_ram (
      .clock (clock), .addr (acc_addr), .we (acc_we), .wdata (acc_wdata), .rdata (acc_rdata)
   );

   // saturated results with flag
   sfm_ram #(.W(RES_W), .DEPTH(MAX_STATES), .AW(ST_W)) u_res_ram (
      .clock (clock), .addr (res_addr), .we (res_we), .wdata (res_wdata), .rdata (res_rdata)
   );

   // position to row
   sfm_div #(.N_W(TGT_W), .D_W(K_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cnt_rdata),
      .divisor  (k_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // skid stage only fills behind a waiting response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_ff |-> rsp_valid_ff)
      else $error("skid stage full while response register empty");

   // a pending read never meets a full skid stage
   a_pend_no_skid: assert property (@(posedge clock) disable iff (reset)
      !(rd_pend_ff && skid_ff))
      else $error("read data arrived with skid stage full");

   // counted update lands on a row in use
   a_q_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_ADD) |-> (32'(row_ff) < 32'(n_ff)))
      else $error("counted update outside active rows");

   // row pass writes only active rows
   a_acc_row_range: assert property (@(posedge clock) disable iff (reset)
      (acc_we && (state_ff == ST_A_ACC || state_ff == ST_A_ZERO))
         |-> (32'(r_ff) < 32'(n_ff)))
      else $error("row accumulator written beyond active rows");

   // clearing pass covers every result element
   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && state_in != ST_CLEAR) |-> res_last)
      else $error("clearing pass ended early");

endmodule
